// ===== hw/rtl/psa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pooled slot allocator package
// Shared widths, codes, defaults and the controller/datapath handshake types.
// ----------------------------------------------------------------------------
package psa_pkg;

  // field widths
  localparam int OFFSET_W  = 18;
  localparam int STEP_W    = 9;
  localparam int POOL_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // parameter defaults
  localparam int DEF_SLOTS_PER_POOL = 1024;
  localparam int DEF_POOL_COUNT     = 5;

  // step register reset value
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(32);

  // request modes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FIFO_FULL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RESOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SAMPLER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TARGET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DEPTH    = 2'd3;

  // pool codes with a step register of their own
  localparam logic [POOL_W-1:0] POOL_SAMPLER = 3'd1;
  localparam logic [POOL_W-1:0] POOL_TARGET  = 3'd2;
  localparam logic [POOL_W-1:0] POOL_DEPTH   = 3'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;     // latch the request word
    logic exec;        // evaluate and update pool state
    logic take_rdata;  // free store read data is ready
  } psa_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic pop_hit;     // request pops from the free FIFO
  } psa_sts_t;

endpackage : psa_pkg
`default_nettype wire

// ===== hw/rtl/pooled_slot_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pooled slot allocator
// Per-pool bump allocation with a FIFO of freed slots for reuse.
// ----------------------------------------------------------------------------
// A request word is taken on a clock edge with start high and busy low; busy
// then stays high until the request is finished. A release, a fresh (bump)
// allocation or any failed request passes the capture and execute states,
// the result being registered at the execute edge. An allocation served
// from the free FIFO adds a state for the registered read of the free store
// memory. done_o is a one-cycle strobe and the receiver must take the result
// when it appears. The free store holds POOL_COUNT * SLOTS_PER_POOL offsets,
// is guarded by per-pool counts and needs no clearing after reset. Offsets
// are relative to the heap start; status 1 flags an exhausted pool or a bad
// pool index, status 2 a full free FIFO. Step registers must be written only
// while busy is low; the block does not enforce this.
// ----------------------------------------------------------------------------
module pooled_slot_allocator
  import psa_pkg::*;
#(
  parameter int SLOTS_PER_POOL = DEF_SLOTS_PER_POOL,
  parameter int POOL_COUNT     = DEF_POOL_COUNT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [STEP_W-1:0]    cfg_data_i,
  // request word
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 mode_i,
  input  wire logic [POOL_W-1:0]    pool_i,
  input  wire logic [OFFSET_W-1:0]  slot_offset_i,
  // result word
  output logic                      done_o,
  output logic [OFFSET_W-1:0]       granted_offset_o,
  output logic                      reused_o,
  output logic [STATUS_W-1:0]       status_o
);

  psa_cmd_t cmd;
  psa_sts_t sts;

  psa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  psa_dp #(
    .SLOTS_PER_POOL (SLOTS_PER_POOL),
    .POOL_COUNT     (POOL_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mode_i           (mode_i),
    .pool_i           (pool_i),
    .slot_offset_i    (slot_offset_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .done_o           (done_o),
    .granted_offset_o (granted_offset_o),
    .reused_o         (reused_o),
    .status_o         (status_o)
  );

endmodule : pooled_slot_allocator
`default_nettype wire

// ===== hw/rtl/psa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : psa_ram
`default_nettype wire

// ===== hw/rtl/psa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pooled slot allocator controller
// Sequences capture, execute and the free store read of one request word.
// ----------------------------------------------------------------------------
module psa_ctrl
  import psa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire psa_sts_t sts_i,
  output logic          busy,
  output psa_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.pop_hit ? S_RDATA : S_IDLE;
      end
      S_RDATA: begin
        cmd_o.take_rdata = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // a captured word is always executed next cycle
  a_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.exec)
    else $error("capture not followed by execute");

  // read data is only taken right after a popping execute
  a_rdata_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_rdata |-> $past(cmd_o.exec && sts_i.pop_hit))
    else $error("read data taken without a pop");

endmodule : psa_ctrl
`default_nettype wire

// ===== hw/rtl/psa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pooled slot allocator datapath
// Step registers, per-pool bump and FIFO pointers, free store and result word.
// ----------------------------------------------------------------------------
module psa_dp
  import psa_pkg::*;
#(
  parameter int SLOTS_PER_POOL = DEF_SLOTS_PER_POOL,
  parameter int POOL_COUNT     = DEF_POOL_COUNT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [STEP_W-1:0]    cfg_data_i,
  input  wire logic                 mode_i,
  input  wire logic [POOL_W-1:0]    pool_i,
  input  wire logic [OFFSET_W-1:0]  slot_offset_i,
  input  wire psa_cmd_t             cmd_i,
  output psa_sts_t                  sts_o,
  output logic                      done_o,
  output logic [OFFSET_W-1:0]       granted_offset_o,
  output logic                      reused_o,
  output logic [STATUS_W-1:0]       status_o
);

  localparam int SlotW    = $clog2(SLOTS_PER_POOL);
  localparam int CntW     = $clog2(SLOTS_PER_POOL + 1);
  localparam int Depth    = POOL_COUNT * SLOTS_PER_POOL;
  localparam int AddrW    = $clog2(Depth);
  localparam int PoolIdxW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

  localparam logic [POOL_W:0]  PoolLimit = (POOL_W + 1)'(POOL_COUNT);
  localparam logic [CntW-1:0]  CntFull   = CntW'(SLOTS_PER_POOL);
  localparam logic [SlotW-1:0] SlotLast  = SlotW'(SLOTS_PER_POOL - 1);
  localparam logic [AddrW-1:0] PoolSpan  = AddrW'(SLOTS_PER_POOL);

  // step registers
  logic [STEP_W-1:0] step_resource_q, step_sampler_q, step_target_q, step_depth_q;

  // request word
  logic                mode_q;
  logic [POOL_W-1:0]   pool_q;
  logic [OFFSET_W-1:0] offset_q;

  // per-pool state
  logic [OFFSET_W-1:0] bump_q [POOL_COUNT];
  logic [SlotW-1:0]    head_q [POOL_COUNT];
  logic [SlotW-1:0]    tail_q [POOL_COUNT];
  logic [CntW-1:0]     cnt_q  [POOL_COUNT];

  // result word
  logic                done_q;
  logic [OFFSET_W-1:0] granted_q;
  logic                reused_q;
  logic [STATUS_W-1:0] status_q;

  // decode
  logic [PoolIdxW-1:0] pidx;
  logic                pool_ok;
  logic [STEP_W-1:0]   step_sel;
  logic [OFFSET_W-1:0] cur_bump;
  logic [SlotW-1:0]    cur_head, cur_tail, head_nxt, tail_nxt;
  logic [CntW-1:0]     cur_cnt;
  logic                fifo_empty, fifo_full;
  logic [OFFSET_W:0]   bump_sum;
  logic                pop_hit, push_ok, bump_ok;
  logic [STATUS_W-1:0] res_status;
  logic [AddrW-1:0]    pool_base, raddr, waddr;
  logic                ram_re, ram_we;
  logic [OFFSET_W-1:0] rdata;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_resource_q <= STEP_RESET;
      step_sampler_q  <= STEP_RESET;
      step_target_q   <= STEP_RESET;
      step_depth_q    <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_RESOURCE: step_resource_q <= cfg_data_i;
        REG_STEP_SAMPLER:  step_sampler_q  <= cfg_data_i;
        REG_STEP_TARGET:   step_target_q   <= cfg_data_i;
        REG_STEP_DEPTH:    step_depth_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      pool_q   <= pool_i;
      offset_q <= slot_offset_i;
    end
  end

  // pool decode and decisions
  always_comb begin
    pidx    = pool_q[PoolIdxW-1:0];
    pool_ok = ({1'b0, pool_q} < PoolLimit);

    case (pool_q)
      POOL_SAMPLER: step_sel = step_sampler_q;
      POOL_TARGET:  step_sel = step_target_q;
      POOL_DEPTH:   step_sel = step_depth_q;
      default:      step_sel = step_resource_q;
    endcase

    cur_bump = pool_ok ? bump_q[pidx] : '0;
    cur_head = pool_ok ? head_q[pidx] : '0;
    cur_tail = pool_ok ? tail_q[pidx] : '0;
    cur_cnt  = pool_ok ? cnt_q[pidx]  : '0;

    fifo_empty = (cur_cnt == '0);
    fifo_full  = (cur_cnt == CntFull);
    bump_sum   = {1'b0, cur_bump} + (OFFSET_W + 1)'(step_sel);

    pop_hit = pool_ok && (mode_q == MODE_ALLOC) && !fifo_empty;
    bump_ok = pool_ok && (mode_q == MODE_ALLOC) && fifo_empty && !bump_sum[OFFSET_W];
    push_ok = pool_ok && (mode_q == MODE_RELEASE) && !fifo_full;

    head_nxt = (cur_head == SlotLast) ? '0 : cur_head + 1'b1;
    tail_nxt = (cur_tail == SlotLast) ? '0 : cur_tail + 1'b1;

    if (!pool_ok) begin
      res_status = ST_EXHAUSTED;
    end else if (mode_q == MODE_ALLOC) begin
      res_status = (fifo_empty && !bump_ok) ? ST_EXHAUSTED : ST_OK;
    end else begin
      res_status = fifo_full ? ST_FIFO_FULL : ST_OK;
    end

    pool_base = AddrW'(pidx) * PoolSpan;
    raddr     = pool_base + AddrW'(cur_head);
    waddr     = pool_base + AddrW'(cur_tail);
    ram_re    = cmd_i.exec && pop_hit;
    ram_we    = cmd_i.exec && push_ok;
  end

  // per-pool bump offsets and FIFO pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        bump_q[p] <= '0;
        head_q[p] <= '0;
        tail_q[p] <= '0;
        cnt_q[p]  <= '0;
      end
    end else if (cmd_i.exec) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        if (pidx == PoolIdxW'(p)) begin
          if (bump_ok) begin
            bump_q[p] <= bump_sum[OFFSET_W-1:0];
          end
          if (pop_hit) begin
            head_q[p] <= head_nxt;
            cnt_q[p]  <= cur_cnt - 1'b1;
          end
          if (push_ok) begin
            tail_q[p] <= tail_nxt;
            cnt_q[p]  <= cur_cnt + 1'b1;
          end
        end
      end
    end
  end

  // free store, one region per pool
  psa_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (Depth)
  ) u_free_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (offset_q),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.exec && !pop_hit) || cmd_i.take_rdata;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_rdata) begin
      granted_q <= rdata;
      reused_q  <= 1'b1;
      status_q  <= ST_OK;
    end else if (cmd_i.exec && !pop_hit) begin
      granted_q <= bump_ok ? cur_bump : '0;
      reused_q  <= 1'b0;
      status_q  <= res_status;
    end
  end

  assign sts_o.pop_hit    = pop_hit;
  assign done_o           = done_q;
  assign granted_offset_o = granted_q;
  assign reused_o         = reused_q;
  assign status_o         = status_q;

  // a failed request never grants or reuses a slot
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (status_q != ST_OK) |-> (granted_q == '0) && !reused_q)
    else $error("failed request carries a grant");

  // a result word follows a finishing execute or a free store read
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.exec && !pop_hit) || $past(cmd_i.take_rdata))
    else $error("result strobe without a finished request");

endmodule : psa_dp
`default_nettype wire
